// File: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue: command and
// status codes, cell operations, controller states and field widths.
// ----------------------------------------------------------------------------
package spq_pkg;

   // fixed field widths of the request and response beats
   localparam int VALUE_BITS     = 32;
   localparam int ITEM_PRI_BITS  = 16;
   localparam int CMD_BITS       = 3;
   localparam int COUNT_OUT_BITS = 5;
   localparam int EXT_PRI_BITS   = 32;

   // request command codes (codes 6 and 7 are ignored)
   typedef enum logic [CMD_BITS-1:0] {
      CMD_INSERT   = 3'd0,
      CMD_DEL_PRI  = 3'd1,
      CMD_DEL_DATA = 3'd2,
      CMD_CLEAR    = 3'd3,
      CMD_LIST_ALL = 3'd4,
      CMD_LIST_PRI = 3'd5
   } cmd_type;

   // response status codes
   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_ENTRY = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_NONE  = 2'd3
   } status_type;

   // operation broadcast to every cell of the chain
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_POP    = 2'd2,
      CELL_CLEAR  = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        push;   // on a pop, append the head entry at the tail
   } cell_ctrl_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_EXEC   = 2'd1,
      ST_SCAN   = 2'd2,
      ST_FINISH = 2'd3
   } state_type;

endpackage

// File: hw/rtl/spq_if.sv
// ----------------------------------------------------------------------------
// spq request and response channels
// Valid/ready channels carrying one command beat and one result beat.
// ----------------------------------------------------------------------------
interface spq_req_if;
   import spq_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [CMD_BITS-1:0]          cmd;
   logic signed [VALUE_BITS-1:0] item_value;
   logic signed [ITEM_PRI_BITS-1:0] item_priority;

   modport source (output valid, cmd, item_value, item_priority, input ready);
   modport sink   (input valid, cmd, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;

   logic                            valid;
   logic                            ready;
   status_type                      status;
   logic signed [VALUE_BITS-1:0]    entry_value;
   logic signed [ITEM_PRI_BITS-1:0] entry_priority;
   logic [COUNT_OUT_BITS-1:0]       removed;
   logic [COUNT_OUT_BITS-1:0]       occupancy;
   logic                            last;

   modport source (output valid, status, entry_value, entry_priority, removed, occupancy,
                   last, input ready);
   modport sink   (input valid, status, entry_value, entry_priority, removed, occupancy,
                   last, output ready);
endinterface

// File: hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain. Holds a valid bit, a data word and a
// priority, and takes its next content from itself, a neighbor or the
// broadcast entry according to the operation of the cycle.
// ----------------------------------------------------------------------------
module spq_cell #(
   parameter int PRIORITY_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  spq_pkg::cell_ctrl_type             ctrl,
   // broadcast entry: key on insert, popped head on pop
   input  logic [spq_pkg::VALUE_BITS-1:0]     new_value,
   input  logic signed [PRIORITY_BITS-1:0]    new_pri,
   // neighbor toward the head
   input  logic                               left_valid,
   input  logic                               left_after,
   input  logic [spq_pkg::VALUE_BITS-1:0]     left_value,
   input  logic signed [PRIORITY_BITS-1:0]    left_pri,
   // neighbor toward the tail
   input  logic                               right_valid,
   input  logic [spq_pkg::VALUE_BITS-1:0]     right_value,
   input  logic signed [PRIORITY_BITS-1:0]    right_pri,
   // own content
   output logic                               valid,
   output logic                               after,
   output logic [spq_pkg::VALUE_BITS-1:0]     value,
   output logic signed [PRIORITY_BITS-1:0]    pri
);
   import spq_pkg::*;

   logic                            valid_ff, valid_in;
   logic [VALUE_BITS-1:0]           value_ff, value_in;
   logic signed [PRIORITY_BITS-1:0] pri_ff, pri_in;

   // new entry belongs at or before this slot
   assign after = !valid_ff || (pri_ff > new_pri);

   // next content
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      pri_in   = pri_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
         end
         CELL_INSERT: begin
            if (after && left_after) begin
               valid_in = left_valid;
               value_in = left_value;
               pri_in   = left_pri;
            end else if (after) begin
               valid_in = 1'b1;
               value_in = new_value;
               pri_in   = new_pri;
            end
         end
         CELL_POP: begin
            // shift toward the head, append recirculated entry behind the last one
            if (right_valid) begin
               valid_in = 1'b1;
               value_in = right_value;
               pri_in   = right_pri;
            end else if (valid_ff && ctrl.push) begin
               valid_in = 1'b1;
               value_in = new_value;
               pri_in   = new_pri;
            end else begin
               valid_in = 1'b0;
            end
         end
         CELL_CLEAR: begin
            valid_in = 1'b0;
         end
      endcase
   end

   // slot registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      pri_ff   <= pri_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign pri   = pri_ff;

endmodule

// File: hw/rtl/spq_chain.sv
// ----------------------------------------------------------------------------
// spq_chain
// Row of queue cells kept compacted at the head in ascending priority
// order. Wires each cell to its neighbors and broadcasts the new entry.
// ----------------------------------------------------------------------------
module spq_chain #(
   parameter int DEPTH,
   parameter int PRIORITY_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  spq_pkg::cell_ctrl_type             ctrl,
   input  logic [spq_pkg::VALUE_BITS-1:0]     key_value,
   input  logic signed [PRIORITY_BITS-1:0]    key_pri,
   output logic [spq_pkg::VALUE_BITS-1:0]     head_value,
   output logic signed [PRIORITY_BITS-1:0]    head_pri
);
   import spq_pkg::*;

   logic [DEPTH-1:0]                cell_valid;
   logic [DEPTH-1:0]                cell_after;
   logic [VALUE_BITS-1:0]           cell_value [DEPTH];
   logic signed [PRIORITY_BITS-1:0] cell_pri   [DEPTH];
   logic [VALUE_BITS-1:0]           new_value;
   logic signed [PRIORITY_BITS-1:0] new_pri;

   // key goes in on insert, the head recirculates on pop
   assign new_value = (ctrl.op == CELL_INSERT) ? key_value : cell_value[0];
   assign new_pri   = (ctrl.op == CELL_INSERT) ? key_pri   : cell_pri[0];

   assign head_value = cell_value[0];
   assign head_pri   = cell_pri[0];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                            l_valid, l_after, r_valid;
      logic [VALUE_BITS-1:0]           l_value, r_value;
      logic signed [PRIORITY_BITS-1:0] l_pri, r_pri;

      // head side neighbor
      if (i == 0) begin : g_first
         assign l_valid = 1'b0;
         assign l_after = 1'b0;
         assign l_value = '0;
         assign l_pri   = '0;
      end else begin : g_inner_l
         assign l_valid = cell_valid[i-1];
         assign l_after = cell_after[i-1];
         assign l_value = cell_value[i-1];
         assign l_pri   = cell_pri[i-1];
      end

      // tail side neighbor
      if (i == DEPTH - 1) begin : g_last
         assign r_valid = 1'b0;
         assign r_value = '0;
         assign r_pri   = '0;
      end else begin : g_inner_r
         assign r_valid = cell_valid[i+1];
         assign r_value = cell_value[i+1];
         assign r_pri   = cell_pri[i+1];
      end

      spq_cell #(
         .PRIORITY_BITS (PRIORITY_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_value   (new_value),
         .new_pri     (new_pri),
         .left_valid  (l_valid),
         .left_after  (l_after),
         .left_value  (l_value),
         .left_pri    (l_pri),
         .right_valid (r_valid),
         .right_value (r_value),
         .right_pri   (r_pri),
         .valid       (cell_valid[i]),
         .after       (cell_after[i]),
         .value       (cell_value[i]),
         .pri         (cell_pri[i])
      );
   end

endmodule

// File: hw/rtl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Priority queue of up to DEPTH entries held in a shift chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one command beat (insert, delete by priority, delete by
//   data and priority, clear, list all, list one priority). rsp_ch returns
//   one result beat per command, or one per listed entry with last set on
//   the final beat; an empty listing returns a single 'none' beat.
//   Entries are kept in ascending priority, older first among equals.
// Timing:
//   insert, clear and unused codes: result loaded from the execute state.
//   deletes and listings: one pass over all stored entries; the chain pops
//   its head once a cycle and appends kept entries at the tail, and a listing
//   pauses while a match waits for the output register. A new command is taken
//   once the current one has loaded its last result, one command at a time.
// Reset:
//   synchronous; the queue comes up empty, no stored data is cleared.
// Stall:
//   results sit in an output register; while rsp_ch is stalled a listing
//   pauses at a match it cannot send, and a taken command waits to load its result.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
   parameter int DEPTH         = 16,
   parameter int PRIORITY_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch
);
   import spq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   // controller state
   state_type                       state_ff, state_in;
   logic [CMD_BITS-1:0]             cmd_ff, cmd_in;
   logic [VALUE_BITS-1:0]           key_value_ff, key_value_in;
   logic signed [PRIORITY_BITS-1:0] key_pri_ff, key_pri_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [CW-1:0]                   steps_ff, steps_in;
   logic [CW-1:0]                   kept_ff, kept_in;
   logic                            pend_valid_ff, pend_valid_in;
   logic [VALUE_BITS-1:0]           pend_value_ff, pend_value_in;
   logic signed [PRIORITY_BITS-1:0] pend_pri_ff, pend_pri_in;

   // response register
   logic                            rsp_valid_ff;
   status_type                      rsp_status_ff, rsp_status_in;
   logic [VALUE_BITS-1:0]           rsp_value_ff, rsp_value_in;
   logic [ITEM_PRI_BITS-1:0]        rsp_pri_ff, rsp_pri_in;
   logic [COUNT_OUT_BITS-1:0]       rsp_removed_ff, rsp_removed_in;
   logic [COUNT_OUT_BITS-1:0]       rsp_occ_ff, rsp_occ_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic                            rsp_load;

   cell_ctrl_type                   ctrl;
   logic [VALUE_BITS-1:0]           head_value;
   logic signed [PRIORITY_BITS-1:0] head_pri;
   logic                            out_free;
   logic                            head_hit;
   logic                            is_delete;
   logic signed [EXT_PRI_BITS-1:0]  req_pri_wide;
   logic signed [EXT_PRI_BITS-1:0]  pend_pri_wide;

   spq_chain #(
      .DEPTH         (DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .key_value  (key_value_ff),
      .key_pri    (key_pri_ff),
      .head_value (head_value),
      .head_pri   (head_pri)
   );

   // priority wraps to the stored width, and back to 16 bits on output
   assign req_pri_wide  = EXT_PRI_BITS'(req_ch.item_priority);
   assign pend_pri_wide = EXT_PRI_BITS'(pend_pri_ff);

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign is_delete = (cmd_ff == CMD_DEL_PRI) || (cmd_ff == CMD_DEL_DATA);
   assign head_hit  = (cmd_ff == CMD_LIST_ALL) ||
                      ((head_pri == key_pri_ff) &&
                       ((cmd_ff != CMD_DEL_DATA) || (head_value == key_value_ff)));

   // next state and outputs
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      key_value_in   = key_value_ff;
      key_pri_in     = key_pri_ff;
      count_in       = count_ff;
      steps_in       = steps_ff;
      kept_in        = kept_ff;
      pend_valid_in  = pend_valid_ff;
      pend_value_in  = pend_value_ff;
      pend_pri_in    = pend_pri_ff;
      ctrl.op        = CELL_HOLD;
      ctrl.push      = 1'b0;
      rsp_load       = 1'b0;
      rsp_status_in  = STAT_DONE;
      rsp_value_in   = '0;
      rsp_pri_in     = '0;
      rsp_removed_in = '0;
      rsp_occ_in     = COUNT_OUT_BITS'(count_ff);
      rsp_last_in    = 1'b1;
      req_ch.ready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               cmd_in        = req_ch.cmd;
               key_value_in  = req_ch.item_value;
               key_pri_in    = req_pri_wide[PRIORITY_BITS-1:0];
               steps_in      = count_ff;
               kept_in       = '0;
               pend_valid_in = 1'b0;
               case (req_ch.cmd) inside
                  CMD_DEL_PRI, CMD_DEL_DATA, CMD_LIST_ALL, CMD_LIST_PRI: begin
                     state_in = (count_ff == '0) ? ST_FINISH : ST_SCAN;
                  end
                  default: begin
                     state_in = ST_EXEC;
                  end
               endcase
            end
         end

         ST_EXEC: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               case (cmd_ff)
                  CMD_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        ctrl.op    = CELL_INSERT;
                        count_in   = count_ff + 1'b1;
                        rsp_occ_in = COUNT_OUT_BITS'(count_ff + 1'b1);
                     end
                  end
                  CMD_CLEAR: begin
                     ctrl.op        = CELL_CLEAR;
                     count_in       = '0;
                     rsp_removed_in = COUNT_OUT_BITS'(count_ff);
                     rsp_occ_in     = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (is_delete) begin
               // drop hits, recirculate the rest
               ctrl.op   = CELL_POP;
               ctrl.push = !head_hit;
               kept_in   = kept_ff + CW'(!head_hit);
               steps_in  = steps_ff - 1'b1;
               if (steps_ff == CW'(1)) begin
                  state_in = ST_FINISH;
               end
            end else if (!(head_hit && pend_valid_ff && !out_free)) begin
               // listing: hold one match back so the final one can carry last
               ctrl.op   = CELL_POP;
               ctrl.push = 1'b1;
               steps_in  = steps_ff - 1'b1;
               if (steps_ff == CW'(1)) begin
                  state_in = ST_FINISH;
               end
               if (head_hit) begin
                  pend_valid_in = 1'b1;
                  pend_value_in = head_value;
                  pend_pri_in   = head_pri;
                  if (pend_valid_ff) begin
                     rsp_load      = 1'b1;
                     rsp_status_in = STAT_ENTRY;
                     rsp_value_in  = pend_value_ff;
                     rsp_pri_in    = pend_pri_wide[ITEM_PRI_BITS-1:0];
                     rsp_last_in   = 1'b0;
                  end
               end
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               if (is_delete) begin
                  count_in       = kept_ff;
                  rsp_removed_in = COUNT_OUT_BITS'(count_ff - kept_ff);
                  rsp_occ_in     = COUNT_OUT_BITS'(kept_ff);
               end else if (pend_valid_ff) begin
                  rsp_status_in = STAT_ENTRY;
                  rsp_value_in  = pend_value_ff;
                  rsp_pri_in    = pend_pri_wide[ITEM_PRI_BITS-1:0];
               end else begin
                  rsp_status_in = STAT_NONE;
               end
            end
         end
      endcase
   end

   // controller registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_value_ff  <= key_value_in;
      key_pri_ff    <= key_pri_in;
      steps_ff      <= steps_in;
      kept_ff       <= kept_in;
      pend_value_ff <= pend_value_in;
      pend_pri_ff   <= pend_pri_in;
   end

   // response output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_value_ff   <= rsp_value_in;
         rsp_pri_ff     <= rsp_pri_in;
         rsp_removed_ff <= rsp_removed_in;
         rsp_occ_ff     <= rsp_occ_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.entry_value    = rsp_value_ff;
   assign rsp_ch.entry_priority = rsp_pri_ff;
   assign rsp_ch.removed        = rsp_removed_ff;
   assign rsp_ch.occupancy      = rsp_occ_ff;
   assign rsp_ch.last           = rsp_last_ff;

endmodule

// File: tb/sorted_priority_queue_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit_test
// Drives command beats into the priority queue and checks every result beat
// against a typed-in result or a shadow queue kept in the bench. A short table
// of commands comes first, then random rounds of inserts, listings, deletes,
// clears and unused codes, under three mixes of sender and receiver stalls.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_test;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH   = 16;
   localparam int RANDOM_ITEMS  = 137;
   localparam int DRAIN_CYCLES  = 40;
   localparam int DIRECTED_ROWS = 23;

   // command codes the block ignores
   localparam logic [CMD_BITS-1:0] CMD_RESERVED_6 = 3'd6;
   localparam logic [CMD_BITS-1:0] CMD_RESERVED_7 = 3'd7;

   typedef struct packed {
      status_type                      status;
      logic signed [VALUE_BITS-1:0]    value;
      logic signed [ITEM_PRI_BITS-1:0] prio;
      logic [COUNT_OUT_BITS-1:0]       removed;
      logic [COUNT_OUT_BITS-1:0]       occupancy;
      logic                            last;
   } result_beat_type;

   // one command, with a typed-in result where it is obvious
   typedef struct packed {
      logic [CMD_BITS-1:0]             cmd;
      logic signed [VALUE_BITS-1:0]    value;
      logic signed [ITEM_PRI_BITS-1:0] prio;
      logic                            typed;
      status_type                      status;
      logic [COUNT_OUT_BITS-1:0]       removed;
      logic [COUNT_OUT_BITS-1:0]       occupancy;
   } command_row_type;

   logic clock;
   logic reset;

   spq_req_if req_ch ();
   spq_rsp_if rsp_ch ();

   sorted_priority_queue_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow copy of the stored entries, oldest first among equals
   logic signed [VALUE_BITS-1:0]    held_value [QUEUE_DEPTH];
   logic signed [ITEM_PRI_BITS-1:0] held_prio  [QUEUE_DEPTH];
   int                              held_count;

   result_beat_type awaited_results [$];

   int send_idle_pct;
   int rsp_idle_pct;
   int error_count;
   int beats_checked;
   int full_drops;
   int empty_listings;
   int commands_sent;
   int cmd_tally [8];

   command_row_type directed_rows [DIRECTED_ROWS] = '{
      '{CMD_LIST_ALL,   32'sd0,          16'sd0,       1'b1, STAT_NONE, 5'd0, 5'd0},
      '{CMD_DEL_PRI,    32'sd0,          16'sd0,       1'b1, STAT_DONE, 5'd0, 5'd0},
      '{CMD_CLEAR,      32'sd0,          16'sd0,       1'b1, STAT_DONE, 5'd0, 5'd0},
      '{CMD_INSERT,     32'sh7fffffff,   16'sh7fff,    1'b1, STAT_DONE, 5'd0, 5'd1},
      // new smallest priority goes to the head
      '{CMD_INSERT,     32'sh80000000,   16'sh8000,    1'b1, STAT_DONE, 5'd0, 5'd2},
      '{CMD_INSERT,     32'sd0,          16'sd0,       1'b1, STAT_DONE, 5'd0, 5'd3},
      '{CMD_INSERT,     -32'sd1,         16'sd0,       1'b1, STAT_DONE, 5'd0, 5'd4},
      '{CMD_INSERT,     32'sd5,          16'sd0,       1'b1, STAT_DONE, 5'd0, 5'd5},
      '{CMD_INSERT,     -32'sd1,         16'sd0,       1'b1, STAT_DONE, 5'd0, 5'd6},
      '{CMD_LIST_ALL,   32'sd0,          16'sd0,       1'b0, STAT_DONE, 5'd0, 5'd0},
      '{CMD_LIST_PRI,   32'sd0,          16'sd0,       1'b0, STAT_DONE, 5'd0, 5'd0},
      '{CMD_LIST_PRI,   32'sd0,          16'sh7fff,    1'b0, STAT_DONE, 5'd0, 5'd0},
      '{CMD_LIST_PRI,   32'sd0,          16'sd7,       1'b1, STAT_NONE, 5'd0, 5'd6},
      // both copies of a duplicated entry go at once
      '{CMD_DEL_DATA,   -32'sd1,         16'sd0,       1'b1, STAT_DONE, 5'd2, 5'd4},
      '{CMD_DEL_DATA,   32'sd99,         16'sd0,       1'b1, STAT_DONE, 5'd0, 5'd4},
      '{CMD_DEL_DATA,   32'sh7fffffff,   16'sd0,       1'b1, STAT_DONE, 5'd0, 5'd4},
      '{CMD_DEL_PRI,    32'sd0,          16'sd0,       1'b1, STAT_DONE, 5'd2, 5'd2},
      '{CMD_RESERVED_6, 32'sd0,          16'sd0,       1'b1, STAT_DONE, 5'd0, 5'd2},
      '{CMD_RESERVED_7, 32'shffffffff,   16'shffff,    1'b1, STAT_DONE, 5'd0, 5'd2},
      '{CMD_LIST_ALL,   32'sd0,          16'sd0,       1'b0, STAT_DONE, 5'd0, 5'd0},
      '{CMD_DEL_PRI,    32'sd0,          16'sh8000,    1'b1, STAT_DONE, 5'd1, 5'd1},
      '{CMD_CLEAR,      32'sd0,          16'sd0,       1'b1, STAT_DONE, 5'd1, 5'd0},
      '{CMD_LIST_PRI,   32'sd0,          16'sd0,       1'b1, STAT_NONE, 5'd0, 5'd0}
   };

   // clock
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // run limit
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // result checker
   always @(posedge clock) begin : check_results
      result_beat_type want;
      result_beat_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got = '{rsp_ch.status, rsp_ch.entry_value, rsp_ch.entry_priority,
                 rsp_ch.removed, rsp_ch.occupancy, rsp_ch.last};
         if (awaited_results.size() == 0) begin
            error_count++;
            $display("%0t: result beat with none awaited: status %s value %0d prio %0d",
                     $time, got.status.name(), got.value, got.prio);
         end else begin
            want = awaited_results.pop_front();
            beats_checked++;
            if (want.status == STAT_FULL) full_drops++;
            if (want.status == STAT_NONE) empty_listings++;
            if (got !== want) begin
               error_count++;
               $display("%0t: expected status %s value %0d prio %0d removed %0d occ %0d last %0d",
                        $time, want.status.name(), want.value, want.prio, want.removed,
                        want.occupancy, want.last);
               $display("%0t: actual   status %s value %0d prio %0d removed %0d occ %0d last %0d",
                        $time, got.status.name(), got.value, got.prio, got.removed,
                        got.occupancy, got.last);
            end
         end
      end
   end

   // apply one command to the shadow queue and return its result beats
   task automatic model_command(input logic [CMD_BITS-1:0] cmd,
                                input logic signed [VALUE_BITS-1:0] value,
                                input logic signed [ITEM_PRI_BITS-1:0] prio,
                                output result_beat_type beats [$]);
      int pos;
      int kept;
      int i;
      result_beat_type b;
      beats = {};
      b = '{STAT_DONE, '0, '0, '0, '0, 1'b1};
      case (cmd) inside
         CMD_INSERT: begin
            if (held_count >= QUEUE_DEPTH) begin
               b.status = STAT_FULL;
            end else begin
               // behind every entry of lower or equal priority
               pos = 0;
               while (pos < held_count && held_prio[pos] <= prio) pos++;
               for (i = held_count; i > pos; i--) begin
                  held_value[i] = held_value[i-1];
                  held_prio[i]  = held_prio[i-1];
               end
               held_value[pos] = value;
               held_prio[pos]  = prio;
               held_count++;
            end
         end
         CMD_DEL_PRI, CMD_DEL_DATA: begin
            kept = 0;
            for (i = 0; i < held_count; i++) begin
               if (!(held_prio[i] == prio && (cmd == CMD_DEL_PRI || held_value[i] == value)))
               begin
                  held_value[kept] = held_value[i];
                  held_prio[kept]  = held_prio[i];
                  kept++;
               end
            end
            b.removed  = COUNT_OUT_BITS'(held_count - kept);
            held_count = kept;
         end
         CMD_CLEAR: begin
            b.removed  = COUNT_OUT_BITS'(held_count);
            held_count = 0;
         end
         CMD_LIST_ALL, CMD_LIST_PRI: begin
            for (i = 0; i < held_count; i++) begin
               if (cmd == CMD_LIST_ALL || held_prio[i] == prio) begin
                  b.status    = STAT_ENTRY;
                  b.value     = held_value[i];
                  b.prio      = held_prio[i];
                  b.occupancy = COUNT_OUT_BITS'(held_count);
                  b.last      = 1'b0;
                  beats.push_back(b);
               end
            end
            if (beats.size() == 0) b.status = STAT_NONE;
            else beats[beats.size()-1].last = 1'b1;
         end
         default: ;
      endcase
      if (beats.size() == 0) begin
         b.occupancy = COUNT_OUT_BITS'(held_count);
         beats.push_back(b);
      end
   endtask

   // present one command beat, wait for it to be taken, then predict
   task automatic send_command(input logic [CMD_BITS-1:0] cmd,
                               input logic signed [VALUE_BITS-1:0] value,
                               input logic signed [ITEM_PRI_BITS-1:0] prio,
                               input logic typed,
                               input result_beat_type typed_beat);
      result_beat_type beats [$];
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.cmd           <= cmd;
      req_ch.item_value    <= value;
      req_ch.item_priority <= prio;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      model_command(cmd, value, prio, beats);
      if (typed) awaited_results.push_back(typed_beat);
      else foreach (beats[k]) awaited_results.push_back(beats[k]);
      commands_sent++;
      cmd_tally[cmd]++;
   endtask

   // hold the sender until every awaited beat is back
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   // mostly small priorities so that equal ones and matches are common
   function automatic logic signed [ITEM_PRI_BITS-1:0] pick_priority();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return ITEM_PRI_BITS'($signed($urandom_range(0, 6)) - 3);
      if (r < 72) return 16'sh8000;
      if (r < 79) return 16'sh7fff;
      return ITEM_PRI_BITS'($urandom);
   endfunction

   // insert until the store overflows by one or two beats
   task automatic fill_to_full();
      int n;
      n = QUEUE_DEPTH - held_count + $urandom_range(1, 2);
      repeat (n) send_command(CMD_INSERT, $urandom, pick_priority(), 1'b0, '0);
   endtask

   // one random round: mostly well-formed traffic on stored entries, some noise
   task automatic random_round();
      int r;
      int idx;
      logic signed [VALUE_BITS-1:0]    value;
      logic signed [ITEM_PRI_BITS-1:0] prio;
      r     = $urandom_range(0, 99);
      idx   = (held_count > 0) ? $urandom_range(0, held_count - 1) : 0;
      value = $urandom;
      prio  = pick_priority();
      // target a stored entry most of the time
      if (held_count > 0 && $urandom_range(0, 99) < 80) begin
         prio = held_prio[idx];
         if ($urandom_range(0, 99) < 85) value = held_value[idx];
      end
      if (r < 6) begin
         fill_to_full();
      end else if (r < 36) begin
         repeat ($urandom_range(1, 6)) begin
            if (held_count > 0 && $urandom_range(0, 99) < 10)
               send_command(CMD_INSERT, held_value[idx], held_prio[idx], 1'b0, '0);
            else
               send_command(CMD_INSERT, $urandom, pick_priority(), 1'b0, '0);
         end
      end else if (r < 50) begin
         send_command(CMD_LIST_ALL, $urandom, pick_priority(), 1'b0, '0);
      end else if (r < 61) begin
         send_command(CMD_LIST_PRI, value, prio, 1'b0, '0);
      end else if (r < 72) begin
         send_command(CMD_DEL_PRI, value, prio, 1'b0, '0);
      end else if (r < 85) begin
         send_command(CMD_DEL_DATA, value, prio, 1'b0, '0);
      end else if (r < 90) begin
         send_command(CMD_CLEAR, value, prio, 1'b0, '0);
      end else if (r < 95) begin
         send_command(($urandom_range(0, 1) != 0) ? CMD_RESERVED_6 : CMD_RESERVED_7,
                      $urandom, ITEM_PRI_BITS'($urandom), 1'b0, '0);
      end else begin
         send_command(CMD_BITS'($urandom), $urandom, ITEM_PRI_BITS'($urandom), 1'b0, '0);
      end
   endtask

   // stimulus
   initial begin : stimulus
      int phase;
      int target;
      req_ch.valid         <= 1'b0;
      req_ch.cmd           <= CMD_INSERT;
      req_ch.item_value    <= '0;
      req_ch.item_priority <= '0;
      reset                <= 1'b1;
      held_count     = 0;
      error_count    = 0;
      beats_checked  = 0;
      full_drops     = 0;
      empty_listings = 0;
      commands_sent  = 0;
      foreach (cmd_tally[k]) cmd_tally[k] = 0;
      send_idle_pct = 11;
      rsp_idle_pct  = 61;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[k]) begin
         send_command(directed_rows[k].cmd, directed_rows[k].value, directed_rows[k].prio,
                      directed_rows[k].typed,
                      '{directed_rows[k].status, '0, '0, directed_rows[k].removed,
                        directed_rows[k].occupancy, 1'b1});
      end

      // random rounds under three stall mixes
      for (phase = 0; phase < 3; phase++) begin
         if (phase > 0) wait_for_results();
         send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 61 : 0;
         rsp_idle_pct  = (phase == 0) ? 61 : (phase == 1) ? 11 : 0;
         fill_to_full();
         target = DIRECTED_ROWS + (phase + 1) * RANDOM_ITEMS / 3;
         while (commands_sent < target) random_round();
      end

      // drain
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d commands: %0d inserts, %0d deletes, %0d clears, %0d listings, %0d unused",
               commands_sent, cmd_tally[CMD_INSERT], cmd_tally[CMD_DEL_PRI] +
               cmd_tally[CMD_DEL_DATA], cmd_tally[CMD_CLEAR], cmd_tally[CMD_LIST_ALL] +
               cmd_tally[CMD_LIST_PRI], cmd_tally[CMD_RESERVED_6] + cmd_tally[CMD_RESERVED_7]);
      $display("checked %0d result beats: %0d full drops, %0d empty listings, %0d errors",
               beats_checked, full_drops, empty_listings, error_count);
      if (error_count == 0 && awaited_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_cell.sv
hw/rtl/spq_chain.sv
hw/rtl/sorted_priority_queue_unit.sv
tb/sorted_priority_queue_unit_test.sv
